// ===== rtl/core/glob_path_matcher_macros.svh =====
`ifndef GLOB_PATH_MATCHER_MACROS_SVH
`define GLOB_PATH_MATCHER_MACROS_SVH

// Property that holds at every clock edge out of reset.
`define GPM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define GPM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gpm_pkg.sv =====
package gpm_pkg;

    localparam int MAX_TOKENS_DEF = 32;
    localparam int MAX_SEPARATORS = 4;
    localparam int SEP_REGS       = 4;
    localparam int SEP_LIMIT      = (MAX_SEPARATORS < SEP_REGS) ? MAX_SEPARATORS : SEP_REGS;

    localparam logic [7:0] ESC_BYTE  = 8'h5C;
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] SEP_RESET = 8'h2F;

    typedef enum logic [1:0] {
        FUNC_PAT_BYTE = 2'd0,
        FUNC_PAT_END  = 2'd1,
        FUNC_TGT_BYTE = 2'd2,
        FUNC_TGT_END  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_LIT  = 2'd0,
        KIND_STAR = 2'd1,
        KIND_DEEP = 2'd2
    } tok_kind_t;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_EMPTY    = 3'd1,
        ERR_ESCAPE   = 3'd2,
        ERR_STARS    = 3'd3,
        ERR_GLOBSTAR = 3'd4,
        ERR_LONG     = 3'd5,
        ERR_NOPAT    = 3'd6
    } err_t;

    typedef enum logic [2:0] {
        CFG_SEP_COUNT  = 3'd0,
        CFG_SEP_CHAR_0 = 3'd1,
        CFG_SEP_CHAR_1 = 3'd2,
        CFG_SEP_CHAR_2 = 3'd3,
        CFG_SEP_CHAR_3 = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MOP_HOLD  = 2'd0,
        MOP_CLEAR = 2'd1,
        MOP_START = 2'd2,
        MOP_STEP  = 2'd3
    } match_op_t;

    typedef struct packed {
        logic [2:0]                sep_count;
        logic [SEP_REGS-1:0][7:0]  sep_chars;
    } sep_cfg_t;

    typedef struct packed {
        match_op_t  op;
        logic       sep_hit;
        logic [7:0] data;
        logic       wr_a;
        tok_kind_t  kind_a;
        logic [7:0] char_a;
        logic       wr_b;
        tok_kind_t  kind_b;
        logic [7:0] char_b;
    } cell_ctl_t;

    typedef struct packed {
        err_t err;
        logic ok;
        logic hit_en;
    } res_t;

    function automatic logic is_sep(sep_cfg_t cfg, logic [7:0] b);
        logic [2:0] lim;
        logic       hit;
        lim = (cfg.sep_count > 3'(SEP_LIMIT)) ? 3'(SEP_LIMIT) : cfg.sep_count;
        hit = 1'b0;
        for (int i = 0; i < SEP_REGS; i++) begin
            if ((3'(i) < lim) && (cfg.sep_chars[i] == b)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ===== rtl/core/gpm_if.sv =====
interface gpm_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface gpm_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] error_code;
    logic       pattern_ok;
    logic       is_match;

    modport source (output valid, output error_code, output pattern_ok, output is_match,
                    input ready);
    modport sink   (input valid, input error_code, input pattern_ok, input is_match,
                    output ready);
endinterface

// ===== rtl/core/gpm_cell.sv =====
module gpm_cell
    import gpm_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic [CNT_W-1:0] idx_a,
    input  logic [CNT_W-1:0] idx_b,
    input  logic [CNT_W-1:0] cnt,
    input  logic             adv_in,
    input  logic             skip_in,
    output logic             adv_out,
    output logic             skip_out,
    output logic             hit
);

    localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

    tok_kind_t  kind_reg, kind_next;
    logic [7:0] char_reg, char_next;
    logic       act_reg, act_next;
    logic       valid, nonlit, stay, raw, fresh, tail;

    always_comb
    begin
        kind_next = kind_reg;
        char_next = char_reg;
        if (ctl.wr_a && (idx_a == POS))
        begin
            kind_next = ctl.kind_a;
            char_next = ctl.char_a;
        end
        else if (ctl.wr_b && (idx_b == POS))
        begin
            kind_next = ctl.kind_b;
            char_next = ctl.char_b;
        end
    end

    always_comb
    begin
        valid    = (POS < cnt);
        tail     = (POS == cnt);
        nonlit   = valid && (kind_next != KIND_LIT);
        stay     = act_reg && nonlit && ((kind_next == KIND_DEEP) || !ctl.sep_hit);
        adv_out  = act_reg && valid && (kind_next == KIND_LIT) && (char_next == ctl.data);
        case (ctl.op)
            MOP_STEP:  raw = stay || adv_in;
            MOP_START: raw = (IDX == 0);
            default:   raw = 1'b0;
        endcase
        skip_out = raw && nonlit;
        fresh    = raw || skip_in;
        case (ctl.op)
            MOP_HOLD:  act_next = act_reg;
            MOP_CLEAR: act_next = 1'b0;
            default:   act_next = fresh;
        endcase
        hit = tail && ((ctl.op == MOP_STEP) ? fresh : act_reg);
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        char_reg <= char_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule

// ===== rtl/core/gpm_compiler.sv =====
`include "glob_path_matcher_macros.svh"

module gpm_compiler
    import gpm_pkg::*;
#(
    parameter int MAX_TOKENS = MAX_TOKENS_DEF,
    parameter int CNT_W      = $clog2(MAX_TOKENS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  func_t            func,
    input  logic [7:0]       data_byte,
    input  sep_cfg_t         sep_cfg,
    input  logic             sep_hit,
    output cell_ctl_t        ctl,
    output logic [CNT_W-1:0] idx_a,
    output logic [CNT_W-1:0] idx_b,
    output logic [CNT_W-1:0] cnt,
    output res_t             res
);

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_TOKENS);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             loaded_reg, loaded_next;
    logic             esc_reg, esc_next;
    logic [1:0]       star_reg, star_next;
    logic             gws_reg, gws_next;
    err_t             err_reg, err_next;
    tok_kind_t        last_kind_reg, last_kind_next;
    logic [7:0]       last_char_reg, last_char_next;

    logic [CNT_W-1:0] base, base_p1;
    logic             base_full, last_sep, edge_ok;
    logic             fl_push, fl_gws;
    tok_kind_t        fl_kind;
    err_t             fl_err;

    assign last_sep = is_sep(sep_cfg, last_char_reg);

    always_comb
    begin
        base      = loaded_reg ? '0 : count_reg;
        base_p1   = base + CNT_W'(1);
        base_full = (base >= CNT_LIMIT);
        edge_ok   = (base == '0) || ((last_kind_reg == KIND_LIT) && last_sep);
        fl_push   = 1'b0;
        fl_kind   = KIND_STAR;
        fl_err    = ERR_OK;
        fl_gws    = 1'b0;
        case (star_reg)
            2'd1:
            begin
                if (base_full)
                    fl_err = ERR_LONG;
                else
                    fl_push = 1'b1;
            end
            2'd2:
            begin
                if (!edge_ok)
                    fl_err = ERR_GLOBSTAR;
                else if (base_full)
                    fl_err = ERR_LONG;
                else
                begin
                    fl_push = 1'b1;
                    fl_kind = KIND_DEEP;
                    fl_gws  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        logic       pa, pb, gws_v, lit_full;
        tok_kind_t  ka, kb;
        logic [7:0] ca, cb;
        err_t       err_v;
        match_op_t  op;

        pa       = 1'b0;
        pb       = 1'b0;
        ka       = KIND_LIT;
        kb       = KIND_LIT;
        ca       = data_byte;
        cb       = data_byte;
        gws_v    = gws_reg;
        lit_full = 1'b0;
        err_v    = err_reg;
        op       = MOP_HOLD;

        loaded_next = loaded_reg;
        count_next  = count_reg;
        esc_next    = esc_reg;
        star_next   = star_reg;
        gws_next    = gws_reg;
        err_next    = err_reg;
        res         = '{err: ERR_OK, ok: 1'b0, hit_en: 1'b0};

        if (take)
        begin
            case (func)
                FUNC_PAT_BYTE:
                begin
                    if (loaded_reg)
                    begin
                        loaded_next = 1'b0;
                        op          = MOP_CLEAR;
                    end
                    if (err_reg != ERR_OK)
                    begin
                        err_v = err_reg;
                    end
                    else if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        if (gws_reg)
                        begin
                            gws_v = 1'b0;
                            if (!sep_hit)
                                err_v = ERR_GLOBSTAR;
                        end
                        if (err_v == ERR_OK)
                        begin
                            if (base_full)
                                err_v = ERR_LONG;
                            else
                                pa = 1'b1;
                        end
                        gws_next = gws_v;
                    end
                    else if (data_byte == STAR_BYTE)
                    begin
                        if (star_reg == 2'd2)
                            err_v = ERR_STARS;
                        else
                            star_next = star_reg + 2'd1;
                    end
                    else
                    begin
                        star_next = 2'd0;
                        err_v     = fl_err;
                        if (fl_err == ERR_OK)
                        begin
                            pa    = fl_push;
                            ka    = fl_kind;
                            ca    = '0;
                            gws_v = gws_reg || fl_gws;
                            if (data_byte == ESC_BYTE)
                            begin
                                esc_next = 1'b1;
                            end
                            else
                            begin
                                if (gws_v)
                                begin
                                    gws_v = 1'b0;
                                    if (!sep_hit)
                                        err_v = ERR_GLOBSTAR;
                                end
                                if (err_v == ERR_OK)
                                begin
                                    lit_full = fl_push ? (base_p1 >= CNT_LIMIT) : base_full;
                                    if (lit_full)
                                        err_v = ERR_LONG;
                                    else if (fl_push)
                                        pb = 1'b1;
                                    else
                                    begin
                                        pa = 1'b1;
                                        ka = KIND_LIT;
                                        ca = data_byte;
                                    end
                                end
                            end
                            gws_next = gws_v;
                        end
                    end
                    err_next   = err_v;
                    count_next = base + CNT_W'(pa) + CNT_W'(pb);
                    res.err    = err_v;
                end
                FUNC_PAT_END:
                begin
                    if (loaded_reg)
                    begin
                        op     = MOP_START;
                        res.ok = 1'b1;
                    end
                    else
                    begin
                        if (err_reg == ERR_OK)
                        begin
                            if ((count_reg == '0) && (star_reg == 2'd0) && !esc_reg)
                                err_v = ERR_EMPTY;
                            else if (esc_reg)
                                err_v = ERR_ESCAPE;
                            else
                            begin
                                err_v = fl_err;
                                pa    = fl_push;
                                ka    = fl_kind;
                                ca    = '0;
                            end
                        end
                        esc_next  = 1'b0;
                        star_next = 2'd0;
                        gws_next  = 1'b0;
                        err_next  = ERR_OK;
                        if (err_v == ERR_OK)
                        begin
                            loaded_next = 1'b1;
                            op          = MOP_START;
                            count_next  = count_reg + CNT_W'(pa);
                            res.ok      = 1'b1;
                        end
                        else
                        begin
                            pa         = 1'b0;
                            op         = MOP_CLEAR;
                            count_next = '0;
                        end
                        res.err = err_v;
                    end
                end
                FUNC_TGT_BYTE, FUNC_TGT_END:
                begin
                    if (!loaded_reg)
                    begin
                        res.err = ERR_NOPAT;
                    end
                    else
                    begin
                        op         = (func == FUNC_TGT_BYTE) ? MOP_STEP : MOP_START;
                        res.ok     = 1'b1;
                        res.hit_en = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (pb)
        begin
            last_kind_next = kb;
            last_char_next = cb;
        end
        else if (pa)
        begin
            last_kind_next = ka;
            last_char_next = ca;
        end
        else
        begin
            last_kind_next = last_kind_reg;
            last_char_next = last_char_reg;
        end

        ctl = '{op: op, sep_hit: sep_hit, data: data_byte,
                wr_a: pa, kind_a: ka, char_a: ca,
                wr_b: pb, kind_b: kb, char_b: cb};
    end

    assign idx_a = base;
    assign idx_b = base_p1;
    assign cnt   = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            loaded_reg <= 1'b0;
            esc_reg    <= 1'b0;
            star_reg   <= 2'd0;
            gws_reg    <= 1'b0;
            err_reg    <= ERR_OK;
        end
        else
        begin
            count_reg  <= count_next;
            loaded_reg <= loaded_next;
            esc_reg    <= esc_next;
            star_reg   <= star_next;
            gws_reg    <= gws_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_kind_reg <= last_kind_next;
        last_char_reg <= last_char_next;
    end

    `GPM_ASSERT_IMPLY(a_loaded_nonempty, loaded_reg, count_reg != '0, "loaded pattern has no tokens")
    `GPM_ASSERT_IMPLY(a_loaded_clean, loaded_reg, (err_reg == ERR_OK) && !esc_reg && (star_reg == 2'd0) && !gws_reg, "compile state left over with pattern loaded")
    `GPM_ASSERT_NEXT(a_pat_byte_unloads, take && (func == FUNC_PAT_BYTE), !loaded_reg, "pattern byte did not unload pattern")
    `GPM_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_LIMIT, "token count beyond table")

endmodule

// ===== rtl/core/glob_path_matcher.sv =====
// Glob path matcher.
// Channel "item" carries func and data_byte: pattern bytes, then pattern end,
// then target bytes and target end, any number of targets per pattern.
// Channel "result" returns exactly one transaction per item, in order:
// error_code, pattern_ok and is_match (prefix match after a target byte,
// final verdict at target end).
// Separators are to be set by the user over the cfg_wr_en / cfg_index / cfg_data
// write port only while the block is idle; the block itself does not enforce it.
// The result is valid in the cycle after the item is accepted.
// Throughput: one item per cycle; every pattern or target byte is handled in
// one pass through the row of token cells, one per token position plus a tail.
// A result waiting in the output register does not block the next item as
// long as the receiver takes it in the same cycle; while the receiver stalls,
// the result holds and item.ready drops.
// Reset clears the token count, the active set and the compile state, loads
// one separator ('/'), and leaves no pattern loaded. The token table itself
// is not cleared.
`include "glob_path_matcher_macros.svh"

module glob_path_matcher
    import gpm_pkg::*;
#(
    parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    gpm_item_if.sink   item,
    gpm_result_if.source result
);

    localparam int CNT_W = $clog2(MAX_TOKENS + 1);

    logic [2:0]               sep_count_reg;
    logic [SEP_REGS-1:0][7:0] sep_chars_reg;
    sep_cfg_t                 sep_cfg;
    logic                     sep_hit, take;

    cell_ctl_t        ctl;
    logic [CNT_W-1:0] idx_a, idx_b, cnt;
    res_t             res;

    logic [MAX_TOKENS+1:0] adv;
    logic [MAX_TOKENS+1:0] skip;
    logic [MAX_TOKENS:0]   hit_vec;

    logic res_valid_reg, res_valid_next;
    err_t res_err_reg;
    logic res_ok_reg, res_match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_count_reg <= 3'd1;
            sep_chars_reg <= {{((SEP_REGS - 1) * 8){1'b0}}, SEP_RESET};
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_SEP_COUNT:  sep_count_reg    <= cfg_data[2:0];
                CFG_SEP_CHAR_0: sep_chars_reg[0] <= cfg_data;
                CFG_SEP_CHAR_1: sep_chars_reg[1] <= cfg_data;
                CFG_SEP_CHAR_2: sep_chars_reg[2] <= cfg_data;
                CFG_SEP_CHAR_3: sep_chars_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sep_cfg    = '{sep_count: sep_count_reg, sep_chars: sep_chars_reg};
    assign sep_hit    = is_sep(sep_cfg, item.data_byte);
    assign item.ready = !res_valid_reg || result.ready;
    assign take       = item.valid && item.ready;

    gpm_compiler #(
        .MAX_TOKENS (MAX_TOKENS),
        .CNT_W      (CNT_W)
    ) u_compiler (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .func      (func_t'(item.func)),
        .data_byte (item.data_byte),
        .sep_cfg   (sep_cfg),
        .sep_hit   (sep_hit),
        .ctl       (ctl),
        .idx_a     (idx_a),
        .idx_b     (idx_b),
        .cnt       (cnt),
        .res       (res)
    );

    assign adv[0]  = 1'b0;
    assign skip[0] = 1'b0;

    for (genvar i = 0; i <= MAX_TOKENS; i++)
    begin : g_cell
        gpm_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .idx_a    (idx_a),
            .idx_b    (idx_b),
            .cnt      (cnt),
            .adv_in   (adv[i]),
            .skip_in  (skip[i]),
            .adv_out  (adv[i+1]),
            .skip_out (skip[i+1]),
            .hit      (hit_vec[i])
        );
    end

    always_comb
    begin
        if (take)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_err_reg   <= res.err;
            res_ok_reg    <= res.ok;
            res_match_reg <= res.hit_en && (|hit_vec);
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.error_code = res_err_reg;
    assign result.pattern_ok = res_ok_reg;
    assign result.is_match   = res_match_reg;

    `GPM_ASSERT_IMPLY(a_ok_no_err, res_valid_reg && res_ok_reg, res_err_reg == ERR_OK,
        "pattern_ok with nonzero error code")
    `GPM_ASSERT_IMPLY(a_match_needs_ok, res_valid_reg && res_match_reg, res_ok_reg,
        "match reported without loaded pattern")

endmodule
